/* rtl/core/cna_pkg.sv */
package cna_pkg;

    localparam int W = 32;
    localparam int F = 16;
    localparam int PW = 2 * W;
    localparam int SW = PW + 2;
    localparam int R2 = (W + F + 1) / 2;
    localparam int RW2 = 2 * R2;
    localparam int N_STAGES = W + R2 + 4;
    localparam int OP_W = 3;

    localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB  = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL  = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV  = 3'd3;
    localparam logic [OP_W-1:0] OP_CONJ = 3'd4;
    localparam logic [OP_W-1:0] OP_SQRT = 3'd5;
    localparam logic [OP_W-1:0] OP_MAG  = 3'd6;
    localparam logic [OP_W-1:0] OP_EQ   = 3'd7;

    localparam logic [SW-1:0] MAG_POS = (SW'(1) << (W - 1)) - SW'(1);
    localparam logic [SW-1:0] MAG_NEG = SW'(1) << (W - 1);

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic signed [W-1:0] a_re;
        logic signed [W-1:0] a_im;
        logic signed [W-1:0] b_re;
        logic signed [W-1:0] b_im;
    } in_t;

    typedef struct packed {
        logic signed [W-1:0] res_re;
        logic signed [W-1:0] res_im;
        logic                is_equal;
        logic                div_by_zero;
        logic                overflow;
    } out_t;

    typedef struct packed {
        logic [W-1:0] val;
        logic         ovf;
    } sat_t;

    // Operands plus the six registered products.
    typedef struct packed {
        logic [OP_W-1:0]      op;
        logic signed [W-1:0]  a_re;
        logic signed [W-1:0]  a_im;
        logic signed [W-1:0]  b_re;
        logic signed [W-1:0]  b_im;
        logic signed [PW-1:0] pa;
        logic signed [PW-1:0] pb;
        logic signed [PW-1:0] pc;
        logic signed [PW-1:0] pd;
        logic signed [PW-1:0] pe;
        logic signed [PW-1:0] pf;
    } prod_t;

    // One pipeline row: the result so far and the state of the iterative units.
    typedef struct packed {
        logic [OP_W-1:0]     op;
        out_t                res;
        logic signed [W-1:0] ar;
        logic                ai_neg;
        logic [PW-1:0]       den;
        logic [PW-1:0]       rad;
        logic [W+1:0]        mrem;
        logic [W-1:0]        mroot;
        logic                nre_neg;
        logic                nim_neg;
        logic                big_re;
        logic                big_im;
        logic [PW-1:0]       rre;
        logic [PW-1:0]       rim;
        logic [W-1:0]        lre;
        logic [W-1:0]        lim;
        logic [W-1:0]        qre;
        logic [W-1:0]        qim;
        logic [RW2-1:0]      srad;
        logic [RW2-1:0]      trad;
        logic [R2+1:0]       srem;
        logic [R2+1:0]       trem;
        logic [R2-1:0]       sroot;
        logic [R2-1:0]       troot;
    } row_t;

    function automatic logic [SW-1:0] sx_w(input logic signed [W-1:0] x);
        return {{(SW - W){x[W-1]}}, x};
    endfunction

    function automatic logic [SW-1:0] sx_p(input logic signed [PW-1:0] x);
        return {{(SW - PW){x[PW-1]}}, x};
    endfunction

    function automatic logic [SW-1:0] abs_s(input logic [SW-1:0] v);
        return v[SW-1] ? (SW'(0) - v) : v;
    endfunction

    // Clamp a sign and magnitude pair to the signed word range.
    function automatic sat_t sat_mag(input logic neg, input logic [SW-1:0] mag);
        sat_t r;
        r.ovf = 1'b0;
        if (!neg) begin
            if (mag > MAG_POS) begin
                r.val = {1'b0, {(W - 1){1'b1}}};
                r.ovf = 1'b1;
            end else begin
                r.val = mag[W-1:0];
            end
        end else begin
            if (mag > MAG_NEG) begin
                r.val = {1'b1, {(W - 1){1'b0}}};
                r.ovf = 1'b1;
            end else begin
                r.val = W'(0) - mag[W-1:0];
            end
        end
        return r;
    endfunction

    function automatic sat_t sat_sgn(input logic [SW-1:0] v);
        return sat_mag(v[SW-1], abs_s(v));
    endfunction

    // Short operations finish here; long ones get their starting values.
    function automatic row_t first_row(input prod_t p);
        row_t r;
        sat_t sr;
        sat_t si;
        logic [SW-1:0] v_re;
        logic [SW-1:0] v_im;
        logic [SW-1:0] dv_re;
        logic [SW-1:0] dv_im;
        logic [SW-1:0] sq;
        logic [SW-1:0] m_re;
        logic [SW-1:0] m_im;
        r = '0;
        r.op = p.op;
        r.ar = p.a_re;
        r.ai_neg = p.a_im[W-1];
        sr = '0;
        si = '0;
        v_re = '0;
        v_im = '0;
        unique case (p.op)
            OP_ADD: begin
                sr = sat_sgn(sx_w(p.a_re) + sx_w(p.b_re));
                si = sat_sgn(sx_w(p.a_im) + sx_w(p.b_im));
            end
            OP_SUB: begin
                sr = sat_sgn(sx_w(p.a_re) - sx_w(p.b_re));
                si = sat_sgn(sx_w(p.a_im) - sx_w(p.b_im));
            end
            OP_MUL: begin
                v_re = sx_p(p.pa) - sx_p(p.pb);
                v_im = sx_p(p.pc) + sx_p(p.pd);
                sr = sat_mag(v_re[SW-1], abs_s(v_re) >> F);
                si = sat_mag(v_im[SW-1], abs_s(v_im) >> F);
            end
            OP_CONJ: begin
                sr = sat_sgn(sx_w(p.a_re));
                si = sat_sgn(SW'(0) - sx_w(p.a_im));
            end
            OP_EQ: begin
                r.res.is_equal = (p.a_re == p.b_re) && (p.a_im == p.b_im);
            end
            OP_DIV, OP_SQRT, OP_MAG: begin
                sr = '0;
            end
        endcase
        r.res.res_re = $signed(sr.val);
        r.res.res_im = $signed(si.val);
        r.res.overflow = sr.ovf | si.ovf;
        dv_re = sx_p(p.pa) + sx_p(p.pb);
        dv_im = sx_p(p.pd) - sx_p(p.pc);
        m_re = abs_s(dv_re);
        m_im = abs_s(dv_im);
        r.nre_neg = dv_re[SW-1];
        r.nim_neg = dv_im[SW-1];
        r.rre = m_re[PW-1:0];
        r.rim = m_im[PW-1:0];
        sq = sx_p(p.pe) + sx_p(p.pf);
        r.den = sq[PW-1:0];
        r.rad = sq[PW-1:0];
        return r;
    endfunction

    // One root bit of the magnitude.
    function automatic row_t mag_step(input row_t r);
        logic [W+3:0] rx;
        logic [W+3:0] tr;
        rx = {r.mrem, r.rad[PW-1 -: 2]};
        tr = {2'b00, r.mroot, 2'b01};
        r.rad = r.rad << 2;
        if (rx >= tr) begin
            rx = rx - tr;
            r.mroot = {r.mroot[W-2:0], 1'b1};
        end else begin
            r.mroot = {r.mroot[W-2:0], 1'b0};
        end
        r.mrem = rx[W+1:0];
        return r;
    endfunction

    // A quotient of 2^W or more is flagged here; the rest fits W bits.
    function automatic row_t div_pre(input row_t r);
        r.big_re = {{(W - F){1'b0}}, r.rre} >= {r.den, {(W - F){1'b0}}};
        r.big_im = {{(W - F){1'b0}}, r.rim} >= {r.den, {(W - F){1'b0}}};
        r.lre = {r.rre[W-F-1:0], {F{1'b0}}};
        r.lim = {r.rim[W-F-1:0], {F{1'b0}}};
        r.rre = r.rre >> (W - F);
        r.rim = r.rim >> (W - F);
        return r;
    endfunction

    function automatic row_t div_step(input row_t r);
        logic [PW:0] sh_re;
        logic [PW:0] sh_im;
        sh_re = {r.rre, r.lre[W-1]};
        sh_im = {r.rim, r.lim[W-1]};
        r.lre = r.lre << 1;
        r.lim = r.lim << 1;
        if (sh_re >= {1'b0, r.den}) begin
            sh_re = sh_re - {1'b0, r.den};
            r.qre = {r.qre[W-2:0], 1'b1};
        end else begin
            r.qre = {r.qre[W-2:0], 1'b0};
        end
        if (sh_im >= {1'b0, r.den}) begin
            sh_im = sh_im - {1'b0, r.den};
            r.qim = {r.qim[W-2:0], 1'b1};
        end else begin
            r.qim = {r.qim[W-2:0], 1'b0};
        end
        r.rre = sh_re[PW-1:0];
        r.rim = sh_im[PW-1:0];
        return r;
    endfunction

    // Radicands of the two half-angle roots; magnitude results are final here.
    function automatic row_t root_init(input row_t r);
        logic [W+1:0] m;
        logic [W+1:0] s;
        logic [W+1:0] t;
        sat_t sr;
        m = {2'b00, r.mroot};
        s = m + {{2{r.ar[W-1]}}, r.ar};
        t = m - {{2{r.ar[W-1]}}, r.ar};
        r.srad = RW2'(s[W:0]) << (F - 1);
        r.trad = RW2'(t[W:0]) << (F - 1);
        r.srem = '0;
        r.trem = '0;
        r.sroot = '0;
        r.troot = '0;
        if (r.op == OP_MAG) begin
            sr = sat_mag(1'b0, SW'(r.mroot));
            r.res.res_re = $signed(sr.val);
            r.res.overflow = sr.ovf;
        end
        return r;
    endfunction

    function automatic row_t div_fin(input row_t r);
        sat_t sr;
        sat_t si;
        if (r.op == OP_DIV) begin
            if (r.den == '0) begin
                r.res.res_re = '0;
                r.res.res_im = '0;
                r.res.div_by_zero = 1'b1;
                r.res.overflow = 1'b0;
            end else begin
                sr = sat_mag(r.nre_neg, r.big_re ? '1 : SW'(r.qre));
                si = sat_mag(r.nim_neg, r.big_im ? '1 : SW'(r.qim));
                r.res.res_re = $signed(sr.val);
                r.res.res_im = $signed(si.val);
                r.res.overflow = sr.ovf | si.ovf;
            end
        end
        return r;
    endfunction

    // One root bit of each half-angle root.
    function automatic row_t root_step(input row_t r);
        logic [R2+3:0] sx;
        logic [R2+3:0] st;
        logic [R2+3:0] tx;
        logic [R2+3:0] tt;
        sx = {r.srem, r.srad[RW2-1 -: 2]};
        st = {2'b00, r.sroot, 2'b01};
        tx = {r.trem, r.trad[RW2-1 -: 2]};
        tt = {2'b00, r.troot, 2'b01};
        r.srad = r.srad << 2;
        r.trad = r.trad << 2;
        if (sx >= st) begin
            sx = sx - st;
            r.sroot = {r.sroot[R2-2:0], 1'b1};
        end else begin
            r.sroot = {r.sroot[R2-2:0], 1'b0};
        end
        if (tx >= tt) begin
            tx = tx - tt;
            r.troot = {r.troot[R2-2:0], 1'b1};
        end else begin
            r.troot = {r.troot[R2-2:0], 1'b0};
        end
        r.srem = sx[R2+1:0];
        r.trem = tx[R2+1:0];
        return r;
    endfunction

    function automatic row_t root_fin(input row_t r);
        sat_t sr;
        sat_t si;
        if (r.op == OP_SQRT) begin
            sr = sat_mag(1'b0, SW'(r.sroot));
            si = sat_mag(r.ai_neg, SW'(r.troot));
            r.res.res_re = $signed(sr.val);
            r.res.res_im = $signed(si.val);
            r.res.overflow = sr.ovf | si.ovf;
        end
        return r;
    endfunction

endpackage

/* rtl/core/complex_number_alu_top.sv */
// Channel  Direction  Handshake               Payload
// req      in         req_valid / req_stall   in_t: op, a_re, a_im, b_re, b_im
// rsp      out        rsp_valid / rsp_stall   out_t: res_re, res_im, flags
//
// One item enters per cycle while req_stall is low. Every item passes the same
// N_STAGES register stages (W + ceil((W+F)/2) + 4, which is 60 for Q16.16). The
// length is set by the square root: W steps for the magnitude, then ceil((W+F)/2)
// steps for the half-angle roots. Reset clears only the valid bits and the skid flag.
// A stall on rsp is absorbed by a one-item skid register, so req_stall is a
// registered flag.
module complex_number_alu_top
    import cna_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  in_t  req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output out_t rsp
);

    // The whole pipeline moves together; it freezes only while the skid holds an item.
    logic adv;

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] vld_next;

    // Stage zero holds the operands and the six products.
    prod_t prod_reg;
    prod_t prod_next;
    logic signed [W-1:0] sq_x;
    logic signed [W-1:0] sq_y;

    row_t row_reg [1:N_STAGES-1];
    row_t row_next [1:N_STAGES-1];

    logic skid_full_reg;
    logic skid_full_next;
    out_t skid_reg;

    assign adv = !skid_full_reg;
    assign req_stall = skid_full_reg;

    // Square root and magnitude square A; divide squares B for the denominator.
    always_comb
    begin
        if (req.op == OP_SQRT || req.op == OP_MAG)
        begin
            sq_x = req.a_re;
            sq_y = req.a_im;
        end
        else
        begin
            sq_x = req.b_re;
            sq_y = req.b_im;
        end
        prod_next.op = req.op;
        prod_next.a_re = req.a_re;
        prod_next.a_im = req.a_im;
        prod_next.b_re = req.b_re;
        prod_next.b_im = req.b_im;
        prod_next.pa = PW'(req.a_re) * PW'(req.b_re);
        prod_next.pb = PW'(req.a_im) * PW'(req.b_im);
        prod_next.pc = PW'(req.a_re) * PW'(req.b_im);
        prod_next.pd = PW'(req.a_im) * PW'(req.b_re);
        prod_next.pe = PW'(sq_x) * PW'(sq_x);
        prod_next.pf = PW'(sq_y) * PW'(sq_y);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            prod_reg <= prod_next;
        end
    end

    // Stage 1 finishes the short operations and forms the sums. The magnitude root
    // runs in stages 2 to W+1 and the quotient in stages 3 to W+2. Stage W+2 sets up
    // the half-angle roots, stage W+3 finishes the quotient, and the last stage
    // finishes the square root.
    for (genvar k = 1; k < N_STAGES; k++)
    begin : g_stage
        if (k == 1)
        begin : g_first
            always_comb
            begin
                row_next[k] = first_row(prod_reg);
            end
        end
        else
        begin : g_rest
            always_comb
            begin
                row_next[k] = row_reg[k-1];
                if (k <= W + 1)
                begin
                    row_next[k] = mag_step(row_next[k]);
                end
                if (k == 2)
                begin
                    row_next[k] = div_pre(row_next[k]);
                end
                if (k >= 3 && k <= W + 2)
                begin
                    row_next[k] = div_step(row_next[k]);
                end
                if (k == W + 2)
                begin
                    row_next[k] = root_init(row_next[k]);
                end
                if (k == W + 3)
                begin
                    row_next[k] = div_fin(row_next[k]);
                end
                if (k >= W + 3 && k <= W + 2 + R2)
                begin
                    row_next[k] = root_step(row_next[k]);
                end
                if (k == N_STAGES - 1)
                begin
                    row_next[k] = root_fin(row_next[k]);
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                row_reg[k] <= row_next[k];
            end
        end
    end

    always_comb
    begin
        if (adv)
        begin
            vld_next = {vld_reg[N_STAGES-2:0], req_valid};
        end
        else
        begin
            vld_next = vld_reg;
        end
    end

    // The skid catches the last stage's item when the consumer stalls it, so the
    // pipeline can still take one more step.
    always_comb
    begin
        if (skid_full_reg)
        begin
            skid_full_next = rsp_stall;
        end
        else
        begin
            skid_full_next = vld_reg[N_STAGES-1] & rsp_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            skid_full_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            skid_full_reg <= skid_full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!skid_full_reg)
        begin
            skid_reg <= row_reg[N_STAGES-1].res;
        end
    end

    assign rsp_valid = skid_full_reg | vld_reg[N_STAGES-1];
    assign rsp = skid_full_reg ? skid_reg : row_reg[N_STAGES-1].res;

endmodule
